// ===== sv/les_pkg.sv =====
// Package: shared types and constants for the LED effect sequencer.
`timescale 1ns / 1ps
package les_pkg;
   localparam int NUM_STRIPS = 2;
   localparam int LEDS_PER_STRIP = 8;
   localparam int NUM_LEDS = NUM_STRIPS * LEDS_PER_STRIP;
   localparam int LED_W = $clog2(NUM_LEDS);
   localparam int MAX_RESULTS = 16;

   localparam logic [1:0] FX_OFF = 2'd0;
   localparam logic [1:0] FX_STATIC = 2'd1;
   localparam logic [1:0] FX_BLINK = 2'd2;
   localparam logic [1:0] FX_PULSE = 2'd3;

   localparam logic [1:0] REG_BRIGHT = 2'd0;
   localparam logic [1:0] REG_BLINK = 2'd1;
   localparam logic [1:0] REG_PULSE = 2'd2;
   localparam logic [1:0] REG_FADE = 2'd3;

   typedef struct packed {
      logic [1:0] cur_effect;
      logic [31:0] cur_color;
      logic signed [16:0] cur_count;
      logic [31:0] start_time;
      logic [17:0] toggle_counter;
      logic toggle_on;
      logic [7:0] pulse_level;
      logic fade_down;
      logic [1:0] prev_effect;
      logic [31:0] prev_color;
      logic queue_valid;
      logic [1:0] queue_effect;
      logic [31:0] queue_color;
      logic signed [16:0] queue_count;
   } led_state_type;

   localparam led_state_type LED_RESET = '{
      cur_effect: FX_OFF, cur_color: 32'd0, cur_count: 17'sd0, start_time: 32'd0,
      toggle_counter: 18'd0, toggle_on: 1'b0, pulse_level: 8'hFF, fade_down: 1'b0,
      prev_effect: FX_OFF, prev_color: 32'd0, queue_valid: 1'b0, queue_effect: FX_OFF,
      queue_color: 32'd0, queue_count: -17'sd1};
endpackage

// ===== sv/les_scale.sv =====
// Shared 8x8 scaler: product of a channel and a level, divided by 255.
`timescale 1ns / 1ps
module les_scale import les_pkg::*; (
   input  logic [7:0] a,
   input  logic [7:0] b,
   output logic [7:0] q
);
   logic [15:0] p;
   logic [16:0] t;
   always_comb begin
      p = a * b;
      // floor(p/255) for p <= 65025: (p + 1 + (p >> 8)) >> 8
      t = {1'b0, p} + 17'd1 + {9'd0, p[15:8]};
      q = t[15:8];
   end
endmodule

// ===== sv/led_effect_sequencer.sv =====
// Top level: per-LED effect sequencer with a sequential LED walker.
//
// Channels: req_ takes a set or an update word; rsp_ delivers one LED
// color word per written drive, rsp_tlast on the final one of an update.
// csr_ writes brightness, blink and pulse intervals and fade step.
// A set word is accepted in S_IDLE, then S_SET updates one addressed LED per
// cycle (every LED of the strip when all_leds is set).
// An update walks the LEDs one after another: an LED that writes no drive
// passes through the state read and the advance, a written drive also through
// three brightness scalings on the one shared scaler and then the push, and a
// pulse step also through three level scalings first; the push waits on
// output stalls, and a flush ends the update.
// req_tready is low while busy.
// When the receiver stalls, the walker holds on the pending result; the
// final result is buffered until the next one or the walk end sets tlast.
// Reset loads every LED's state, the csr registers, the state, the hold flag and the result count with reset values.
`timescale 1ns / 1ps
module led_effect_sequencer import les_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // tdata: strip_index, led_index, all_leds, effect, color, count, now_ms
   input  logic [87:0] req_tdata,
   // tuser: mode
   input  logic req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // tdata: out_strip, out_led, red, green, blue
   output logic [31:0] rsp_tdata,
   output logic rsp_tlast,
   input  logic csr_we,
   input  logic [1:0] csr_index,
   input  logic [15:0] csr_wdata
);
   typedef enum logic [3:0] {
      S_IDLE, S_SET, S_RD, S_ADV, S_PR, S_PG, S_PB, S_BR, S_BG, S_BB, S_PUSH, S_FLUSH
   } state_type;

   led_state_type leds_ff [NUM_LEDS];
   led_state_type cur_ff, adv;
   state_type state_ff;
   logic [7:0] bright_ff, fade_ff;
   logic [15:0] blink_ff, pulse_ff;
   logic all_ff;
   logic [LED_W-1:0] idx_ff;
   logic [1:0] fx_ff;
   logic [31:0] color_ff, now_ff, drive_ff;
   logic signed [16:0] cnt_ff;
   logic [7:0] r_ff, g_ff, b_ff, sa, sb, sq;
   logic hold_valid_ff;
   logic [31:0] hold_ff;
   logic [4:0] nout_ff;
   logic last_idx;
   logic [LED_W-1:0] first_idx;
   logic addr_ok;

   les_scale u_scale (.a(sa), .b(sb), .q(sq));

   assign last_idx = (idx_ff == LED_W'(NUM_LEDS - 1));
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_PUSH || state_ff == S_FLUSH) && hold_valid_ff;
   assign rsp_tdata = hold_ff;
   assign rsp_tlast = (state_ff == S_FLUSH);

   always_comb begin
      first_idx = LED_W'(req_tdata[0] * LEDS_PER_STRIP);
      addr_ok = (32'(req_tdata[0]) < NUM_STRIPS) &&
                (req_tdata[4] || 32'(req_tdata[3:1]) < LEDS_PER_STRIP);
      if (!req_tdata[4]) first_idx = LED_W'(req_tdata[0] * LEDS_PER_STRIP + req_tdata[3:1]);
   end

   always_comb begin
      sa = r_ff; sb = bright_ff;
      case (state_ff)
         S_PR: begin sa = drive_ff[23:16]; sb = cur_ff.pulse_level; end
         S_PG: begin sa = drive_ff[15:8]; sb = cur_ff.pulse_level; end
         S_PB: begin sa = drive_ff[7:0]; sb = cur_ff.pulse_level; end
         S_BR: begin sa = drive_ff[23:16]; sb = bright_ff; end
         S_BG: begin sa = drive_ff[15:8]; sb = bright_ff; end
         S_BB: begin sa = drive_ff[7:0]; sb = bright_ff; end
         default: begin sa = r_ff; sb = bright_ff; end
      endcase
   end

   // advance of the LED held in cur_ff
   logic [31:0] elapsed;
   logic [31:0] static_lim;
   logic [8:0] lvl_up;
   logic signed [9:0] lvl;
   logic adv_emit, adv_pulse, fin;
   always_comb begin
      adv = cur_ff;
      adv_emit = 1'b0;
      adv_pulse = 1'b0;
      fin = 1'b0;
      elapsed = now_ff - cur_ff.start_time;
      static_lim = 32'(cur_ff.cur_count[15:0]) * 32'd1000;
      lvl_up = 9'd0;
      lvl = 10'sd0;
      case (cur_ff.cur_effect)
         FX_OFF: begin adv_emit = 1'b1; end
         FX_STATIC: begin
            if (cur_ff.cur_count > 0 && elapsed >= static_lim) fin = 1'b1;
            else adv_emit = 1'b1;
         end
         FX_BLINK: begin
            if (elapsed >= 32'(blink_ff)) begin
               adv.start_time = now_ff;
               if (cur_ff.cur_count > 0) begin
                  if (cur_ff.toggle_counter == 18'd0)
                     adv.toggle_counter = {cur_ff.cur_count[16:0], 1'b0};
                  else adv.toggle_counter = cur_ff.toggle_counter - 18'd1;
                  if (cur_ff.toggle_counter == 18'd1) fin = 1'b1;
               end
               adv.toggle_on = ~cur_ff.toggle_on;
               adv_emit = !fin;
            end
         end
         default: begin
            if (elapsed >= 32'(pulse_ff)) begin
               adv.start_time = now_ff;
               lvl_up = {1'b0, cur_ff.pulse_level};
               lvl = cur_ff.fade_down ? $signed({1'b0, lvl_up}) - $signed({2'b0, fade_ff})
                                      : $signed({1'b0, lvl_up}) + $signed({2'b0, fade_ff});
               if (lvl <= 0 || lvl >= 255) begin
                  adv.fade_down = ~cur_ff.fade_down;
                  if (cur_ff.cur_count > 0) begin
                     adv.cur_count = cur_ff.cur_count - 17'sd1;
                     if (cur_ff.cur_count == 17'sd1) fin = 1'b1;
                  end
               end
               adv.pulse_level = lvl < 0 ? 8'd0 : (lvl > 255 ? 8'hFF : lvl[7:0]);
               adv_emit = !fin;
               adv_pulse = 1'b1;
            end
         end
      endcase
      if (fin) begin
         if (cur_ff.queue_valid) begin
            adv.cur_effect = cur_ff.queue_effect;
            adv.cur_color = cur_ff.queue_color;
            adv.cur_count = cur_ff.queue_count;
            adv.queue_valid = 1'b0;
         end else begin
            adv.cur_effect = cur_ff.prev_effect;
            adv.cur_color = cur_ff.prev_color;
            adv.cur_count = -17'sd1;
         end
         adv.start_time = now_ff;
         adv.toggle_counter = 18'd0;
         adv.toggle_on = 1'b0;
         adv.pulse_level = bright_ff;
         adv.fade_down = 1'b0;
      end
   end

   function automatic led_state_type set_led(led_state_type s, logic [1:0] fx,
         logic [31:0] c, logic signed [16:0] n, logic [31:0] now, logic [7:0] br);
      led_state_type o;
      o = s;
      if ((s.cur_effect == FX_BLINK || s.cur_effect == FX_PULSE) && s.cur_count > 0) begin
         o.queue_effect = fx; o.queue_color = c; o.queue_count = n; o.queue_valid = 1'b1;
      end else begin
         if (fx != FX_BLINK && fx != FX_PULSE) begin
            o.prev_effect = s.cur_effect; o.prev_color = s.cur_color;
         end
         o.cur_effect = fx; o.cur_color = c; o.cur_count = n; o.queue_valid = 1'b0;
         o.start_time = now; o.toggle_counter = 18'd0; o.toggle_on = 1'b0;
         o.pulse_level = br; o.fade_down = 1'b0;
      end
      return o;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         for (int i = 0; i < NUM_LEDS; i++) leds_ff[i] <= LED_RESET;
         bright_ff <= 8'd255; blink_ff <= 16'd500; pulse_ff <= 16'd30; fade_ff <= 8'd5;
         hold_valid_ff <= 1'b0;
         nout_ff <= 5'd0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_BRIGHT: bright_ff <= csr_wdata[7:0];
               REG_BLINK: blink_ff <= csr_wdata;
               REG_PULSE: pulse_ff <= csr_wdata;
               REG_FADE: fade_ff <= csr_wdata[7:0];
               default: ;
            endcase
         end
         case (state_ff)
            S_IDLE: if (req_tvalid) begin
               all_ff <= req_tdata[4];
               fx_ff <= req_tdata[6:5];
               color_ff <= req_tdata[38:7];
               cnt_ff <= $signed(req_tdata[55:39]);
               now_ff <= req_tdata[87:56];
               nout_ff <= 5'd0;
               hold_valid_ff <= 1'b0;
               if (req_tuser) begin
                  idx_ff <= '0; state_ff <= S_RD;
               end else if (addr_ok) begin
                  idx_ff <= first_idx; state_ff <= S_SET;
               end
            end
            S_SET: begin
               leds_ff[idx_ff] <= set_led(leds_ff[idx_ff], fx_ff, color_ff, cnt_ff, now_ff,
                                          bright_ff);
               if (all_ff && 32'(idx_ff) % LEDS_PER_STRIP != LEDS_PER_STRIP - 1)
                  idx_ff <= idx_ff + LED_W'(1);
               else state_ff <= S_IDLE;
            end
            S_RD: begin cur_ff <= leds_ff[idx_ff]; state_ff <= S_ADV; end
            S_ADV: begin
               leds_ff[idx_ff] <= adv;
               cur_ff <= adv;
               if (cur_ff.cur_effect == FX_OFF) drive_ff <= 32'd0;
               else if (cur_ff.cur_effect == FX_BLINK && !adv.toggle_on) drive_ff <= 32'd0;
               else drive_ff <= cur_ff.cur_color;
               if (adv_emit && nout_ff < 5'(MAX_RESULTS))
                  state_ff <= adv_pulse ? S_PR : S_BR;
               else if (last_idx) state_ff <= S_FLUSH;
               else begin idx_ff <= idx_ff + LED_W'(1); state_ff <= S_RD; end
            end
            S_PR: begin drive_ff[23:16] <= sq; state_ff <= S_PG; end
            S_PG: begin drive_ff[15:8] <= sq; state_ff <= S_PB; end
            S_PB: begin drive_ff[7:0] <= sq; state_ff <= S_BR; end
            S_BR: begin r_ff <= sq; state_ff <= S_BG; end
            S_BG: begin g_ff <= sq; state_ff <= S_BB; end
            S_BB: begin b_ff <= sq; state_ff <= S_PUSH; end
            S_PUSH: begin
               if (!hold_valid_ff || rsp_tready) begin
                  hold_valid_ff <= 1'b1;
                  hold_ff <= {4'd0, b_ff, g_ff, r_ff,
                              3'(32'(idx_ff) % LEDS_PER_STRIP),
                              1'(32'(idx_ff) / LEDS_PER_STRIP)};
                  nout_ff <= nout_ff + 5'd1;
                  if (last_idx) state_ff <= S_FLUSH;
                  else begin idx_ff <= idx_ff + LED_W'(1); state_ff <= S_RD; end
               end
            end
            S_FLUSH: begin
               if (!hold_valid_ff || rsp_tready) begin
                  hold_valid_ff <= 1'b0; state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("result while idle");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("held result changed");
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      nout_ff <= 5'(MAX_RESULTS)) else $error("result count overflow");
endmodule
